>>> hw/rtl/mics_pkg.sv
// Package for the MIPS integer core: load kinds, status codes, bus codes, state types.
// No dependencies.
`default_nettype none
package mics_pkg;
    localparam logic [31:0] BOOT_ADDR_DEF = 32'hbfc0_0000;
    localparam int unsigned NUM_GPR = 32;
    localparam int unsigned GPR_AW = 5;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_OVF = 3'd1;
    localparam logic [2:0] ST_UNIMP = 3'd2;
    localparam logic [2:0] ST_SYSCALL = 3'd3;
    localparam logic [2:0] ST_UNEXP = 3'd4;

    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_READ = 2'd1;
    localparam logic [1:0] BUS_WRITE = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [2:0] LK_LB = 3'd0;
    localparam logic [2:0] LK_LH = 3'd1;
    localparam logic [2:0] LK_LW = 3'd2;
    localparam logic [2:0] LK_LBU = 3'd3;
    localparam logic [2:0] LK_LHU = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MDU, S_OUT
    } ctl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;      // item accepted, latch inputs
        logic rd_issue;   // register file read (registered)
        logic exec;       // decode and execute
        logic mdu_start;  // kick multiply/divide unit
        logic commit;     // commit architectural state
        logic out_take;   // result item taken
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_mdu;
        logic mdu_done;
    } dp_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/mics_if.sv
// Valid/ready channel interfaces for the core: input, result and config.
// Depends on nothing.
`default_nettype none
interface mics_in_if;
    logic valid;
    logic ready;
    logic func;
    logic [31:0] instr_word;
    logic [31:0] load_data;
    modport source (output valid, func, instr_word, load_data, input ready);
    modport sink (input valid, func, instr_word, load_data, output ready);
endinterface

interface mics_out_if;
    logic valid;
    logic ready;
    logic [31:0] fetch_addr;
    logic [1:0] bus_op;
    logic [31:0] bus_addr;
    logic [1:0] bus_size;
    logic [31:0] write_data;
    logic [2:0] status;
    logic wait_load;
    modport source (output valid, fetch_addr, bus_op, bus_addr, bus_size, write_data,
                    status, wait_load, input ready);
    modport sink (input valid, fetch_addr, bus_op, bus_addr, bus_size, write_data,
                  status, wait_load, output ready);
endinterface

interface mics_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mics_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module mics_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/mics_mdu.sv
// Multi-cycle multiply/divide unit: radix-2 shift-add multiply, restoring divide.
// Uses mics_pkg.
`default_nettype none
module mics_mdu
    import mics_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic [1:0] op,      // 0 mult, 1 multu, 2 div, 3 divu
    input wire logic [31:0] a,
    input wire logic [31:0] b,
    output logic done,
    output logic [31:0] hi,
    output logic [31:0] lo
);
    logic busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;    // product, or {rem, quotient}
    logic [31:0] mc_reg, mc_next;      // multiplicand/divisor magnitude
    logic neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic is_div_reg, is_div_next, zdiv_reg, zdiv_next;
    logic [31:0] a_raw_reg, a_raw_next;
    logic done_reg, done_next;

    logic sgn, na, nb;
    logic [31:0] ma, mb;
    logic [32:0] sum, diff;
    logic [63:0] prod_n;
    logic [31:0] q_fix, r_fix;

    always_comb
    begin
        sgn = ~op[0];
        na = sgn & a[31];
        nb = sgn & b[31];
        ma = na ? (32'd0 - a) : a;
        mb = nb ? (32'd0 - b) : b;
        sum = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? {1'b0, mc_reg} : 33'd0);
        diff = {acc_reg[63:31]} - {1'b0, mc_reg};
    end

    // iteration step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        mc_next = mc_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        is_div_next = is_div_reg;
        zdiv_next = zdiv_reg;
        a_raw_next = a_raw_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            acc_next = {32'd0, ma};
            mc_next = mb;
            is_div_next = op[1];
            neg_q_next = na ^ nb;
            neg_r_next = na;
            zdiv_next = (b == 32'd0);
            a_raw_next = a;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!diff[32])
                begin
                    acc_next = {diff[31:0], acc_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[62:0], 1'b0};
                end
            end
            else
            begin
                acc_next = {sum, acc_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        mc_reg <= mc_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        is_div_reg <= is_div_next;
        zdiv_reg <= zdiv_next;
        a_raw_reg <= a_raw_next;
    end

    // sign fix-up of results, and the result of a divide by zero
    always_comb
    begin
        prod_n = neg_q_reg ? (64'd0 - acc_reg) : acc_reg;
        q_fix = neg_q_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
        r_fix = neg_r_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];
        if (!is_div_reg)
        begin
            hi = prod_n[63:32];
            lo = prod_n[31:0];
        end
        else if (zdiv_reg)
        begin
            hi = a_raw_reg;
            lo = neg_r_reg ? 32'd1 : 32'hffff_ffff;
        end
        else
        begin
            hi = r_fix;
            lo = q_fix;
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

>>> hw/rtl/mics_datapath.sv
// Datapath: input/output registers, register file, ALU, branch, load/store, HI/LO.
// Uses mics_pkg, mics_ram, mics_mdu.
`default_nettype none
module mics_datapath
    import mics_pkg::*;
#(
    parameter logic [31:0] BOOT_ADDR = BOOT_ADDR_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire dp_cmd_t cmd,
    output dp_sts_t sts,
    input wire logic cfg_we,
    input wire logic [31:0] cfg_data,
    input wire logic in_func,
    input wire logic [31:0] in_instr,
    input wire logic [31:0] in_ldata,
    output logic [31:0] fetch_addr,
    output logic [1:0] bus_op,
    output logic [31:0] bus_addr,
    output logic [1:0] bus_size,
    output logic [31:0] write_data,
    output logic [2:0] status,
    output logic wait_load
);
    // latched item
    logic func_reg;
    logic [31:0] iw_reg, ld_reg;
    // architectural state
    logic [31:0] this_reg, this_next, nxt_reg, nxt_next, hi_reg, hi_next, lo_reg, lo_next;
    logic lp_reg, lp_next;
    logic [4:0] ldst_reg, ldst_next;
    logic [2:0] lk_reg, lk_next;
    logic [31:0] gs_valid_reg, gs_valid_next;  // written-since-reset marks per GPR
    logic [31:0] gt_valid_reg;
    // execute results, registered
    logic we_reg, we_next;
    logic [4:0] wa_reg, wa_next;
    logic [31:0] wd_reg, wd_next;
    logic [1:0] bop_reg, bop_next, bsz_reg, bsz_next;
    logic [31:0] ba_reg, ba_next, wdat_reg, wdat_next;
    logic [2:0] st_reg, st_next;
    logic adv_reg, adv_next;
    logic [31:0] nn_reg, nn_next;
    logic mdu_reg, mdu_next;
    logic [1:0] mop_reg, mop_next;
    logic hiw_reg, hiw_next, low_reg, low_next;
    logic [31:0] s_hold_reg, t_hold_reg;
    // load bookkeeping captured at execute, applied at commit
    logic lp_next_hold;
    logic [4:0] ldst_hold;
    logic [2:0] lk_hold;

    logic [31:0] rs_q, rt_q, s, t;
    logic mdu_done;
    logic [31:0] mdu_hi, mdu_lo;

    mics_ram #(.WIDTH(32), .DEPTH(NUM_GPR)) u_rf_s (
        .clk(clk), .we(we_reg & cmd.commit), .waddr(wa_reg), .wdata(wd_reg),
        .raddr(iw_reg[25:21]), .rdata(rs_q)
    );
    mics_ram #(.WIDTH(32), .DEPTH(NUM_GPR)) u_rf_t (
        .clk(clk), .we(we_reg & cmd.commit), .waddr(wa_reg), .wdata(wd_reg),
        .raddr(iw_reg[20:16]), .rdata(rt_q)
    );

    mics_mdu u_mdu (
        .clk(clk), .rst_n(rst_n), .start(cmd.mdu_start), .op(mop_reg),
        .a(s_hold_reg), .b(t_hold_reg), .done(mdu_done), .hi(mdu_hi), .lo(mdu_lo)
    );

    // operands; entries never written read as zero
    assign s = gs_valid_reg[iw_reg[25:21]] ? rs_q : 32'd0;
    assign t = gt_valid_reg[iw_reg[20:16]] ? rt_q : 32'd0;
    assign gt_valid_reg = gs_valid_reg;

    assign sts.need_mdu = mdu_reg;
    assign sts.mdu_done = mdu_done;

    // decode and execute
    always_comb
    begin
        logic [5:0] op, fn;
        logic [4:0] rt, rd, sh;
        logic [31:0] imm, uimm, slot, link, br, ea, r;
        logic take;
        logic [2:0] lk;
        op = iw_reg[31:26];
        rt = iw_reg[20:16];
        rd = iw_reg[15:11];
        sh = iw_reg[10:6];
        fn = iw_reg[5:0];
        imm = {{16{iw_reg[15]}}, iw_reg[15:0]};
        uimm = {16'd0, iw_reg[15:0]};
        slot = nxt_reg;
        link = slot + 32'd4;
        br = slot + {imm[29:0], 2'b00};
        ea = s + imm;
        r = 32'd0;
        take = 1'b0;
        lk = LK_LW;
        we_next = 1'b0;
        wa_next = rd;
        wd_next = 32'd0;
        bop_next = BUS_NONE;
        bsz_next = SZ_BYTE;
        ba_next = 32'd0;
        wdat_next = 32'd0;
        st_next = ST_OK;
        adv_next = 1'b0;
        nn_next = link;
        mdu_next = 1'b0;
        mop_next = 2'd0;
        hiw_next = 1'b0;
        low_next = 1'b0;
        lp_next = lp_reg;
        ldst_next = ldst_reg;
        lk_next = lk_reg;
        if (func_reg)
        begin
            if (!lp_reg)
            begin
                st_next = ST_UNEXP;
            end
            else
            begin
                case (lk_reg)
                    LK_LB: wd_next = {{24{ld_reg[7]}}, ld_reg[7:0]};
                    LK_LH: wd_next = {{16{ld_reg[15]}}, ld_reg[15:0]};
                    LK_LBU: wd_next = {24'd0, ld_reg[7:0]};
                    LK_LHU: wd_next = {16'd0, ld_reg[15:0]};
                    default: wd_next = ld_reg;
                endcase
                we_next = 1'b1;
                wa_next = ldst_reg;
                lp_next = 1'b0;
            end
        end
        else if (lp_reg)
        begin
            st_next = ST_UNEXP;
        end
        else
        begin
            unique case (op)
                6'h00:
                begin
                    we_next = 1'b1;
                    case (fn)
                        6'h00: wd_next = t << sh;
                        6'h02: wd_next = t >> sh;
                        6'h03: wd_next = $signed(t) >>> sh;
                        6'h04: wd_next = t << s[4:0];
                        6'h07: wd_next = $signed(t) >>> s[4:0];
                        6'h08:
                        begin
                            we_next = 1'b0;
                            nn_next = s;
                        end
                        6'h09:
                        begin
                            nn_next = s;
                            wd_next = link;
                        end
                        6'h0c:
                        begin
                            we_next = 1'b0;
                            st_next = ST_SYSCALL;
                        end
                        6'h10: wd_next = hi_reg;
                        6'h11:
                        begin
                            we_next = 1'b0;
                            hiw_next = 1'b1;
                        end
                        6'h12: wd_next = lo_reg;
                        6'h13:
                        begin
                            we_next = 1'b0;
                            low_next = 1'b1;
                        end
                        6'h18, 6'h19, 6'h1a, 6'h1b:
                        begin
                            we_next = 1'b0;
                            mdu_next = 1'b1;
                            mop_next = fn[1:0];
                        end
                        6'h20:
                        begin
                            r = s + t;
                            wd_next = r;
                            if ((s[31] ~^ t[31]) & (r[31] ^ s[31]))
                            begin
                                we_next = 1'b0;
                                st_next = ST_OVF;
                            end
                        end
                        6'h21: wd_next = s + t;
                        6'h23: wd_next = s - t;
                        6'h24: wd_next = s & t;
                        6'h25: wd_next = s | t;
                        6'h27: wd_next = ~(s | t);
                        6'h2a: wd_next = {31'd0, $signed(s) < $signed(t)};
                        6'h2b: wd_next = {31'd0, s < t};
                        default:
                        begin
                            we_next = 1'b0;
                            st_next = ST_UNIMP;
                        end
                    endcase
                end
                6'h01:
                begin
                    case (rt)
                        5'h00, 5'h10: take = s[31];
                        5'h01, 5'h11: take = ~s[31];
                        default: st_next = ST_UNIMP;
                    endcase
                    if (take)
                    begin
                        nn_next = br;
                    end
                    we_next = rt[4];
                    wa_next = 5'd31;
                    wd_next = link;
                end
                6'h02: nn_next = {slot[31:28], iw_reg[25:0], 2'b00};
                6'h03:
                begin
                    nn_next = {slot[31:28], iw_reg[25:0], 2'b00};
                    we_next = 1'b1;
                    wa_next = 5'd31;
                    wd_next = link;
                end
                6'h04: nn_next = (s == t) ? br : link;
                6'h05: nn_next = (s != t) ? br : link;
                6'h06: nn_next = (s[31] || s == 32'd0) ? br : link;
                6'h07: nn_next = (!s[31] && s != 32'd0) ? br : link;
                6'h08:
                begin
                    r = s + imm;
                    we_next = 1'b1;
                    wa_next = rt;
                    wd_next = r;
                    if ((s[31] ~^ imm[31]) & (r[31] ^ s[31]))
                    begin
                        we_next = 1'b0;
                        st_next = ST_OVF;
                    end
                end
                6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0f:
                begin
                    we_next = 1'b1;
                    wa_next = rt;
                    case (op[2:0])
                        3'd1: wd_next = s + imm;
                        3'd2: wd_next = {31'd0, $signed(s) < $signed(imm)};
                        3'd3: wd_next = {31'd0, s < imm};
                        3'd4: wd_next = s & uimm;
                        3'd5: wd_next = s | uimm;
                        default: wd_next = {iw_reg[15:0], 16'd0};
                    endcase
                end
                6'h20, 6'h21, 6'h23, 6'h24, 6'h25:
                begin
                    case (op[2:0])
                        3'd0: lk = LK_LB;
                        3'd1: lk = LK_LH;
                        3'd4: lk = LK_LBU;
                        3'd5: lk = LK_LHU;
                        default: lk = LK_LW;
                    endcase
                    lk_next = lk;
                    ldst_next = rt;
                    lp_next = 1'b1;
                    bop_next = BUS_READ;
                    if (lk == LK_LW)
                    begin
                        bsz_next = SZ_WORD;
                        ba_next = {ea[31:2], 2'b00};
                    end
                    else if (lk == LK_LH || lk == LK_LHU)
                    begin
                        bsz_next = SZ_HALF;
                        ba_next = {ea[31:1], 1'b0};
                    end
                    else
                    begin
                        ba_next = ea;
                    end
                end
                6'h28:
                begin
                    bop_next = BUS_WRITE;
                    ba_next = ea;
                    wdat_next = {24'd0, t[7:0]};
                end
                6'h29:
                begin
                    bop_next = BUS_WRITE;
                    bsz_next = SZ_HALF;
                    ba_next = {ea[31:1], 1'b0};
                    wdat_next = {16'd0, t[15:0]};
                end
                6'h2b:
                begin
                    bop_next = BUS_WRITE;
                    bsz_next = SZ_WORD;
                    ba_next = {ea[31:2], 2'b00};
                    wdat_next = t;
                end
                default: st_next = ST_UNIMP;
            endcase
            if (st_next == ST_UNIMP || st_next == ST_OVF)
            begin
                we_next = 1'b0;
                mdu_next = 1'b0;
                hiw_next = 1'b0;
                low_next = 1'b0;
                bop_next = BUS_NONE;
                bsz_next = SZ_BYTE;
                ba_next = 32'd0;
                wdat_next = 32'd0;
            end
            else
            begin
                adv_next = 1'b1;
            end
        end
        if (wa_next == 5'd0)
        begin
            we_next = 1'b0;
        end
    end

    // commit of architectural state; a config write loads the PC
    always_comb
    begin
        this_next = this_reg;
        nxt_next = nxt_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        gs_valid_next = gs_valid_reg;
        if (cmd.commit)
        begin
            if (adv_reg)
            begin
                this_next = nxt_reg;
                nxt_next = nn_reg;
            end
            if (hiw_reg)
            begin
                hi_next = s_hold_reg;
            end
            if (low_reg)
            begin
                lo_next = s_hold_reg;
            end
            if (mdu_reg)
            begin
                hi_next = mdu_hi;
                lo_next = mdu_lo;
            end
            if (we_reg)
            begin
                gs_valid_next[wa_reg] = 1'b1;
            end
        end
        if (cfg_we)
        begin
            this_next = cfg_data;
            nxt_next = cfg_data + 32'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            this_reg <= BOOT_ADDR;
            nxt_reg <= BOOT_ADDR + 32'd4;
            hi_reg <= 32'd0;
            lo_reg <= 32'd0;
            lp_reg <= 1'b0;
            ldst_reg <= 5'd0;
            lk_reg <= LK_LB;
            gs_valid_reg <= 32'd0;
        end
        else
        begin
            this_reg <= this_next;
            nxt_reg <= nxt_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            gs_valid_reg <= gs_valid_next;
            if (cfg_we)
            begin
                lp_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                lp_reg <= lp_next_hold;
                ldst_reg <= ldst_hold;
                lk_reg <= lk_hold;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg <= in_func;
            iw_reg <= in_instr;
            ld_reg <= in_ldata;
        end
        if (cmd.exec)
        begin
            we_reg <= we_next;
            wa_reg <= wa_next;
            wd_reg <= wd_next;
            bop_reg <= bop_next;
            bsz_reg <= bsz_next;
            ba_reg <= ba_next;
            wdat_reg <= wdat_next;
            st_reg <= st_next;
            adv_reg <= adv_next;
            nn_reg <= nn_next;
            mdu_reg <= mdu_next;
            mop_reg <= mop_next;
            hiw_reg <= hiw_next;
            low_reg <= low_next;
            s_hold_reg <= s;
            t_hold_reg <= t;
            lp_next_hold <= lp_next;
            ldst_hold <= ldst_next;
            lk_hold <= lk_next;
        end
    end

    // result item: fetch address and load wait read committed state, the rest the execute results
    assign fetch_addr = this_reg;
    assign bus_op = bop_reg;
    assign bus_addr = ba_reg;
    assign bus_size = bsz_reg;
    assign write_data = wdat_reg;
    assign status = st_reg;
    assign wait_load = lp_reg;
endmodule
`default_nettype wire

>>> hw/rtl/mics_ctrl.sv
// Controller state machine: sequences read, execute, multiply/divide and output.
// Uses mics_pkg.
`default_nettype none
module mics_ctrl
    import mics_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input wire logic out_ready,
    output logic cfg_ready,
    output dp_cmd_t cmd,
    input wire dp_sts_t sts
);
    ctl_state_t state_reg, state_next;
    logic prev_exec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC: state_next = S_MDU;
            S_MDU:
            begin
                if (!sts.need_mdu || sts.mdu_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT: if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cfg_ready = 1'b1;
                cmd.start = in_valid;
            end
            S_READ: cmd.rd_issue = 1'b1;
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_MDU:
            begin
                cmd.mdu_start = 1'b0;
                cmd.commit = !sts.need_mdu || sts.mdu_done;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                cmd.out_take = out_ready;
            end
            default: cmd = '0;
        endcase
        // MDU kicks off the cycle after execute registers its operands
        if (state_reg == S_MDU && prev_exec_reg && sts.need_mdu)
        begin
            cmd.mdu_start = 1'b1;
            cmd.commit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_exec_reg <= 1'b0;
        end
        else
        begin
            prev_exec_reg <= (state_reg == S_EXEC);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/mips_integer_core_step.sv
// MIPS I integer core, one instruction or load-data item at a time.
// Each item passes accept, register read, execute, commit and output in turn;
// multiply and divide run in the shared shift-add/restoring unit before commit.
// A new item is accepted only once the last result is taken, so an output stall holds input.
// Reset: asynchronous, rst_n low; PC at BOOT_ADDR, HI/LO zero and all GPRs read as zero.
// Depends on mics_pkg, mics_if, mics_ram, mics_mdu, mics_datapath, mics_ctrl.
`default_nettype none
module mips_integer_core_step
    import mics_pkg::*;
#(
    parameter logic [31:0] BOOT_ADDR = BOOT_ADDR_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mics_cfg_if.sink cfg,
    mics_in_if.sink in_ch,
    mics_out_if.source out_ch
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    mics_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cfg_ready(cfg.ready), .cmd(cmd), .sts(sts)
    );

    mics_datapath #(.BOOT_ADDR(BOOT_ADDR)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg.valid & cfg.ready), .cfg_data(cfg.data),
        .in_func(in_ch.func), .in_instr(in_ch.instr_word), .in_ldata(in_ch.load_data),
        .fetch_addr(out_ch.fetch_addr), .bus_op(out_ch.bus_op), .bus_addr(out_ch.bus_addr),
        .bus_size(out_ch.bus_size), .write_data(out_ch.write_data),
        .status(out_ch.status), .wait_load(out_ch.wait_load)
    );

`ifndef SYNTHESIS
    // never accept an input item while a result item is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input accepted during output");
    // an accepted item leads to no result in the next cycle
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("result too early");
    // a result item always carries a valid bus size
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.bus_size != 2'd3)) else $error("bad bus size");
`endif
endmodule
`default_nettype wire
